>>> rtl/ils_pkg.sv
// Shared definitions for the indexed list store: request codes, status codes,
// field widths and the default capacity. No dependencies.
package ils_pkg;

   // Field widths of one request and one response
   localparam int MODE_W   = 3;
   localparam int POS_W    = 8;
   localparam int VALUE_W  = 32;
   localparam int LENGTH_W = 7;
   localparam int STATUS_W = 2;

   // Default number of entries the store can hold
   localparam int DEFAULT_CAPACITY = 64;

   // Request codes
   localparam logic [MODE_W-1:0] MODE_GET  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_HEAD = 3'd1;
   localparam logic [MODE_W-1:0] MODE_TAIL = 3'd2;
   localparam logic [MODE_W-1:0] MODE_AT   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DEL  = 3'd4;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // Read value reported for a get that misses
   localparam logic signed [VALUE_W-1:0] MISS_VALUE = -32'sd1;

endpackage

>>> rtl/ils_store_ram.sv
// Entry memory of the indexed list store: one write port, one read port with
// registered read data. Depends on ils_pkg for the entry width.
module ils_store_ram #(
   parameter int DEPTH = ils_pkg::DEFAULT_CAPACITY,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [AW-1:0]                      wr_addr,
   input  logic signed [ils_pkg::VALUE_W-1:0] wr_data,
   input  logic [AW-1:0]                      rd_addr,
   output logic signed [ils_pkg::VALUE_W-1:0] rd_data
);
   import ils_pkg::*;

   logic signed [VALUE_W-1:0] mem [DEPTH];
   logic signed [VALUE_W-1:0] rd_data_ff;

   // Write one entry when wr_en is set and read one entry every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/indexed_list_store.sv
// Indexed list store: an ordered list of up to CAPACITY signed 32-bit values
// kept packed from position 0, with get, insert at head, tail or before a
// position, and delete at a position; every item gives one response. The list
// lives in a single-port-write, single-port-read memory, and one up/down index
// unit walks it one entry per read and write state pair. A get reads, then
// captures, then responds. An insert moves each entry from the position on up
// one place and writes the value; a delete moves each later entry down one
// place. Rejects for range, a full store or an unused code go straight to the
// finish state. One item is in work at a time: req_stall stays high until the
// response is in the output register. The memory needs no clearing after reset.
module indexed_list_store #(
   parameter int CAPACITY = ils_pkg::DEFAULT_CAPACITY
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ils_pkg::MODE_W-1:0]          req_mode,
   input  logic [ils_pkg::POS_W-1:0]           req_position,
   input  logic signed [ils_pkg::VALUE_W-1:0]  req_item_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [ils_pkg::VALUE_W-1:0]  rsp_read_value,
   output logic                                rsp_found,
   output logic [ils_pkg::LENGTH_W-1:0]        rsp_list_length,
   output logic [ils_pkg::STATUS_W-1:0]        rsp_status
);
   import ils_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > POS_W) ? CW : POS_W;

   typedef enum logic [3:0] {
      S_IDLE, S_GET_RD, S_GET_CAP, S_INS_RD, S_INS_WR, S_INS_PUT,
      S_DEL_RD, S_DEL_WR, S_DEL_END, S_FINISH
   } state_type;

   state_type                 state_ff, state_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [CW-1:0]             idx_ff, idx_in;
   logic [CW-1:0]             tgt_ff, tgt_in;
   logic signed [VALUE_W-1:0] val_ff, val_in;
   logic signed [VALUE_W-1:0] res_read_ff, res_read_in;
   logic                      res_found_ff, res_found_in;
   logic [STATUS_W-1:0]       res_status_ff, res_status_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_read_ff, rsp_read_in;
   logic                      rsp_found_ff, rsp_found_in;
   logic [LENGTH_W-1:0]       rsp_length_ff, rsp_length_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;

   logic                      accept;
   logic                      step_down;
   logic [CW-1:0]             step;
   logic [XW-1:0]             pos_x;
   logic [XW-1:0]             count_x;
   logic [XW-1:0]             at_x;
   logic                      full;
   logic                      wr_en;
   logic [AW-1:0]             wr_addr;
   logic signed [VALUE_W-1:0] wr_data;
   logic [AW-1:0]             rd_addr;
   logic signed [VALUE_W-1:0] rd_data;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   // Shared index unit: step one place down while inserting, up otherwise
   assign step_down = (state_ff == S_INS_RD) || (state_ff == S_INS_WR);
   assign step      = step_down ? (idx_ff - CW'(1)) : (idx_ff + CW'(1));

   // Range checks on a common width
   assign pos_x   = XW'(req_position);
   assign count_x = XW'(count_ff);
   assign full    = (count_ff == CW'(CAPACITY));

   always_comb begin
      case (req_mode)
         MODE_HEAD: at_x = '0;
         MODE_TAIL: at_x = count_x;
         default:   at_x = pos_x;
      endcase
   end

   // Memory port control
   assign wr_en   = (state_ff == S_INS_WR) || (state_ff == S_DEL_WR)
                 || (state_ff == S_INS_PUT);
   assign wr_addr = (state_ff == S_INS_PUT) ? tgt_ff[AW-1:0] : idx_ff[AW-1:0];
   assign wr_data = (state_ff == S_INS_PUT) ? val_ff : rd_data;
   assign rd_addr = (state_ff == S_GET_RD) ? idx_ff[AW-1:0] : step[AW-1:0];

   ils_store_ram #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Sequencer next state
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      tgt_in        = tgt_ff;
      val_in        = val_ff;
      res_read_in   = res_read_ff;
      res_found_in  = res_found_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_read_in   = rsp_read_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_length_in = rsp_length_ff;
      rsp_status_in = rsp_status_ff;

      // Drop the response once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               val_in        = req_item_value;
               res_read_in   = '0;
               res_found_in  = 1'b0;
               res_status_in = STATUS_RANGE;
               state_in      = S_FINISH;
               case (req_mode) inside
                  MODE_GET: begin
                     if (pos_x < count_x) begin
                        idx_in        = CW'(pos_x);
                        res_found_in  = 1'b1;
                        res_status_in = STATUS_DONE;
                        state_in      = S_GET_RD;
                     end else begin
                        res_read_in = MISS_VALUE;
                     end
                  end
                  MODE_HEAD, MODE_TAIL, MODE_AT: begin
                     if (at_x > count_x) begin
                        res_status_in = STATUS_RANGE;
                     end else if (full) begin
                        res_status_in = STATUS_FULL;
                     end else begin
                        idx_in        = count_ff;
                        tgt_in        = CW'(at_x);
                        res_found_in  = 1'b1;
                        res_status_in = STATUS_DONE;
                        state_in      = (at_x == count_x) ? S_INS_PUT : S_INS_RD;
                     end
                  end
                  MODE_DEL: begin
                     if (pos_x < count_x) begin
                        idx_in        = CW'(pos_x);
                        tgt_in        = count_ff - CW'(1);
                        res_found_in  = 1'b1;
                        res_status_in = STATUS_DONE;
                        state_in      = (CW'(pos_x) == count_ff - CW'(1)) ? S_DEL_END
                                                                         : S_DEL_RD;
                     end
                  end
                  default: begin
                     res_status_in = STATUS_RANGE;
                  end
               endcase
            end
         end
         S_GET_RD: begin
            state_in = S_GET_CAP;
         end
         S_GET_CAP: begin
            res_read_in = rd_data;
            state_in    = S_FINISH;
         end
         // Move the entry below idx up into idx
         S_INS_RD: begin
            state_in = S_INS_WR;
         end
         S_INS_WR: begin
            idx_in   = step;
            state_in = (step == tgt_ff) ? S_INS_PUT : S_INS_RD;
         end
         S_INS_PUT: begin
            count_in = count_ff + CW'(1);
            state_in = S_FINISH;
         end
         // Move the entry above idx down into idx
         S_DEL_RD: begin
            state_in = S_DEL_WR;
         end
         S_DEL_WR: begin
            idx_in   = step;
            state_in = (step == tgt_ff) ? S_DEL_END : S_DEL_RD;
         end
         S_DEL_END: begin
            count_in = count_ff - CW'(1);
            state_in = S_FINISH;
         end
         // Load the response once the output register is free
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_read_in   = res_read_ff;
               rsp_found_in  = res_found_ff;
               rsp_length_in = count_x[LENGTH_W-1:0];
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      tgt_ff        <= tgt_in;
      val_ff        <= val_in;
      res_read_ff   <= res_read_in;
      res_found_ff  <= res_found_in;
      res_status_ff <= res_status_in;
      rsp_read_ff   <= rsp_read_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_length_ff <= rsp_length_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_read_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_list_length = rsp_length_ff;
   assign rsp_status      = rsp_status_ff;

endmodule
